>>> sv/spose_pkg.sv
// Shared types, constants and codes for the servo pose interpolator.
package spose_pkg;

   // Channel and field sizes.
   localparam int MAX_CH       = 8;
   localparam int CHANNELS_DEF = 8;
   localparam int ANGLE_W      = 8;
   localparam int PULSE_W      = 12;
   localparam int DUR_W        = 16;
   localparam int TIME_W       = 32;
   localparam int POSE_W       = 4;
   localparam int ID_W         = 5;
   localparam int CSR_INDEX_W  = 4;

   // Pose id that means no pose is held.
   localparam logic [ID_W-1:0] NO_ID = 5'd31;

   // Move fraction is in units of 1/1024.
   localparam int               FRAC_BITS = 10;
   localparam logic [FRAC_BITS:0] FRAC_ONE = 11'd1024;

   // Division by 180 as a multiplication by a scaled reciprocal.
   localparam int               RECIP_SHIFT = 28;
   localparam logic [20:0]      RECIP_180   = 21'd1491309;
   localparam logic [PULSE_W-1:0] PULSE_MAX = 12'd4095;

   // Reset values.
   localparam logic [PULSE_W-1:0] PULSE_MIN_RESET = 12'd480;
   localparam logic [PULSE_W-1:0] PULSE_MAX_RESET = 12'd95;
   localparam logic [DUR_W-1:0]   DUR_RESET       = 16'd1000;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] REG_PULSE_AT_MIN = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PULSE_AT_MAX = 4'd1;

   // Event codes.
   typedef enum logic [1:0] {
      OP_SET    = 2'd0,
      OP_TICK   = 2'd1,
      OP_CANCEL = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_FRAC,
      ST_DIVIDE,
      ST_MIX1,
      ST_MIX2,
      ST_MAP1,
      ST_MAP2,
      ST_MAP3,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [1:0]         op;
      logic [TIME_W-1:0]  now_ms;
      logic [POSE_W-1:0]  pose_id;
      logic [DUR_W-1:0]   duration_ms;
      logic [ANGLE_W-1:0] angle0;
      logic [ANGLE_W-1:0] angle1;
      logic [ANGLE_W-1:0] angle2;
      logic [ANGLE_W-1:0] angle3;
      logic [ANGLE_W-1:0] angle4;
      logic [ANGLE_W-1:0] angle5;
      logic [ANGLE_W-1:0] angle6;
      logic [ANGLE_W-1:0] angle7;
   } req_type;

   typedef struct packed {
      logic [PULSE_W-1:0] pulse0;
      logic [PULSE_W-1:0] pulse1;
      logic [PULSE_W-1:0] pulse2;
      logic [PULSE_W-1:0] pulse3;
      logic [PULSE_W-1:0] pulse4;
      logic [PULSE_W-1:0] pulse5;
      logic [PULSE_W-1:0] pulse6;
      logic [PULSE_W-1:0] pulse7;
      logic               last_of_run;
   } rsp_type;

   // Per-cycle commands from the sequencer to every channel lane.
   typedef struct packed {
      logic load_held_req;
      logic load_held_goal;
      logic load_goal_req;
      logic mix_mult;
      logic mix_add;
      logic mix_rebase;
      logic map_src_mix;
      logic map1;
      logic map2;
      logic map3;
   } lane_ctrl_type;

endpackage

>>> sv/spose_div.sv
// Restoring divider that gives the move fraction elapsed*1024/duration.
module spose_div (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   input  logic [spose_pkg::DUR_W-1:0]              num,
   input  logic [spose_pkg::DUR_W-1:0]              den,
   output logic                                     done,
   output logic [spose_pkg::FRAC_BITS-1:0]          quo
);
   import spose_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [3:0]           cnt_ff, cnt_in;
   logic [DUR_W-1:0]     rem_ff, rem_in;
   logic [FRAC_BITS-1:0] quo_ff, quo_in;
   logic [DUR_W:0]       shifted;
   logic                 fits;

   // One quotient bit per cycle; the numerator is below the denominator.
   always_comb begin
      shifted = {rem_ff, 1'b0};
      fits    = shifted >= {1'b0, den};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = num;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? DUR_W'(shifted - {1'b0, den}) : shifted[DUR_W-1:0];
         quo_in = {quo_ff[FRAC_BITS-2:0], fits};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'(FRAC_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

>>> sv/spose_lane.sv
// One servo channel: held and goal angle, interpolation and pulse mapping.
module spose_lane (
   input  logic                               clock,
   input  logic                               reset,
   input  spose_pkg::lane_ctrl_type           ctrl,
   input  logic [spose_pkg::ANGLE_W-1:0]      req_angle,
   input  logic [spose_pkg::FRAC_BITS:0]      frac,
   input  logic [spose_pkg::PULSE_W-1:0]      pulse_lo,
   input  logic [spose_pkg::PULSE_W-1:0]      pulse_hi,
   output logic                               diff,
   output logic [spose_pkg::PULSE_W-1:0]      pulse
);
   import spose_pkg::*;

   logic [ANGLE_W-1:0]  held_ff, held_in;
   logic [ANGLE_W-1:0]  goal_ff, goal_in;
   logic [ANGLE_W-1:0]  mix_ff, mix_in;
   logic signed [21:0]  mix_prod_ff, mix_prod_in;
   logic                map_neg_ff, map_neg_in;
   logic [19:0]         map_mag_ff, map_mag_in;
   logic [12:0]         map_q_ff, map_q_in;
   logic [PULSE_W-1:0]  pulse_ff, pulse_in;

   logic signed [9:0]   span;
   logic signed [21:0]  adj;
   logic signed [21:0]  step;
   logic [21:0]         mixed;
   logic [ANGLE_W-1:0]  src;
   logic signed [12:0]  range_s;
   logic signed [21:0]  prod1;
   logic [40:0]         prod2;
   logic signed [14:0]  qs;
   logic signed [14:0]  sum;

   assign diff = held_ff != req_angle;

   always_comb begin
      // Interpolation: a + (b - a) * f / 1024, truncated toward zero.
      span  = $signed({2'b0, goal_ff}) - $signed({2'b0, held_ff});
      mix_prod_in = mix_prod_ff;
      if (ctrl.mix_mult) begin
         mix_prod_in = 22'(span * $signed({1'b0, frac}));
      end
      adj   = mix_prod_ff[21] ? mix_prod_ff + 22'sd1023 : mix_prod_ff;
      step  = adj >>> FRAC_BITS;
      mixed = 22'({14'b0, held_ff}) + 22'(step);
      mix_in = mix_ff;
      if (ctrl.mix_add && !ctrl.mix_rebase) begin
         mix_in = mixed[ANGLE_W-1:0];
      end

      // Held and goal angle updates.
      held_in = held_ff;
      goal_in = goal_ff;
      if (ctrl.load_held_req) begin
         held_in = req_angle;
      end else if (ctrl.load_held_goal) begin
         held_in = goal_ff;
      end else if (ctrl.mix_add && ctrl.mix_rebase) begin
         held_in = mixed[ANGLE_W-1:0];
      end
      if (ctrl.load_goal_req) begin
         goal_in = req_angle;
      end

      // Pulse map, first product: (hi - lo) * angle as sign and magnitude.
      src     = ctrl.map_src_mix ? mix_ff : held_ff;
      range_s = $signed({1'b0, pulse_hi}) - $signed({1'b0, pulse_lo});
      prod1   = 22'(range_s * $signed({1'b0, src}));
      map_neg_in = map_neg_ff;
      map_mag_in = map_mag_ff;
      if (ctrl.map1) begin
         map_neg_in = prod1[21];
         map_mag_in = prod1[21] ? 20'(-prod1) : prod1[19:0];
      end

      // Second product: magnitude / 180 by the scaled reciprocal.
      prod2    = 41'(map_mag_ff) * 41'(RECIP_180);
      map_q_in = map_q_ff;
      if (ctrl.map2) begin
         map_q_in = prod2[RECIP_SHIFT+12:RECIP_SHIFT];
      end

      // Apply the sign, add the base count and saturate.
      qs  = map_neg_ff ? -$signed({2'b0, map_q_ff}) : $signed({2'b0, map_q_ff});
      sum = $signed({3'b0, pulse_lo}) + qs;
      pulse_in = pulse_ff;
      if (ctrl.map3) begin
         if (sum < 0) begin
            pulse_in = '0;
         end else if (sum > $signed({3'b0, PULSE_MAX})) begin
            pulse_in = PULSE_MAX;
         end else begin
            pulse_in = sum[PULSE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         goal_ff <= '0;
      end else begin
         held_ff <= held_in;
         goal_ff <= goal_in;
      end
      mix_ff      <= mix_in;
      mix_prod_ff <= mix_prod_in;
      map_neg_ff  <= map_neg_in;
      map_mag_ff  <= map_mag_in;
      map_q_ff    <= map_q_in;
      pulse_ff    <= pulse_in;
   end

   assign pulse = pulse_ff;

endmodule

>>> sv/spose_merge.sv
// Merges the lanes: combines the compare flags and packs the result.
module spose_merge #(
   parameter int CHANNELS = spose_pkg::CHANNELS_DEF
) (
   input  logic [spose_pkg::MAX_CH-1:0]                     diffs,
   input  logic [spose_pkg::MAX_CH-1:0][spose_pkg::PULSE_W-1:0] pulses,
   input  logic                                             last,
   output logic                                             any_diff,
   output spose_pkg::rsp_type                               rsp
);
   import spose_pkg::*;

   logic [MAX_CH-1:0]              used;
   logic [MAX_CH-1:0][PULSE_W-1:0] kept;

   // Only channels that are present take part.
   always_comb begin
      for (int i = 0; i < MAX_CH; i++) begin
         used[i] = diffs[i] && (i < CHANNELS);
         kept[i] = (i < CHANNELS) ? pulses[i] : '0;
      end
   end

   assign any_diff = |used;

   always_comb begin
      rsp.pulse0      = kept[0];
      rsp.pulse1      = kept[1];
      rsp.pulse2      = kept[2];
      rsp.pulse3      = kept[3];
      rsp.pulse4      = kept[4];
      rsp.pulse5      = kept[5];
      rsp.pulse6      = kept[6];
      rsp.pulse7      = kept[7];
      rsp.last_of_run = last;
   end

endmodule

>>> sv/servo_pose_interpolator_top.sv
// Servo pose interpolator: sequencer, pose state, channel lanes and output register.
// An interpolating tick waits on the bit-serial fraction divider; a tick with negative elapsed
// time skips it, a changed set pose goes straight to the pulse map, and a finishing tick
// gives two results.
// One request is in work at a time; the next is accepted once the sequencer is back in
// idle, after any wait for the result to be taken. Reset clears the poses to none, the
// angles to zero, the durations to 1000 and the registers to defaults.
module servo_pose_interpolator_top #(
   parameter int CHANNELS = spose_pkg::CHANNELS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  spose_pkg::req_type                     req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output spose_pkg::rsp_type                     rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [spose_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [spose_pkg::PULSE_W-1:0]          csr_data
);
   import spose_pkg::*;

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [PULSE_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [ID_W-1:0]    held_id_ff, held_id_in, goal_id_ff, goal_id_in;
   logic [DUR_W-1:0]   held_dur_ff, held_dur_in, goal_dur_ff, goal_dur_in;
   logic [TIME_W-1:0]  move_start_ff, move_start_in;
   logic               moving_ff, moving_in;
   logic [FRAC_BITS:0] frac_ff, frac_in;
   logic               job_rebase_ff, job_rebase_in;
   logic               job_mix_ff, job_mix_in;
   logic               emit_two_ff, emit_two_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   lane_ctrl_type              ctrl;
   logic [MAX_CH-1:0][ANGLE_W-1:0] req_angles;
   logic [MAX_CH-1:0]              diffs;
   logic [MAX_CH-1:0][PULSE_W-1:0] pulses;
   logic                           any_diff;
   rsp_type                        merged;
   logic                           div_start, div_done;
   logic [FRAC_BITS-1:0]           div_quo;

   logic [ID_W-1:0]   req_id;
   logic [TIME_W-1:0] elapsed;
   logic              e_neg, e_ge;
   logic              pose_match, set_apply, set_start, set_rebase;
   logic              tick_finish, tick_mix, do_cancel, emit_load;

   assign req_angles[0] = req_ff.angle0;
   assign req_angles[1] = req_ff.angle1;
   assign req_angles[2] = req_ff.angle2;
   assign req_angles[3] = req_ff.angle3;
   assign req_angles[4] = req_ff.angle4;
   assign req_angles[5] = req_ff.angle5;
   assign req_angles[6] = req_ff.angle6;
   assign req_angles[7] = req_ff.angle7;

   // Decisions for the request in hand.
   assign req_id     = {1'b0, req_ff.pose_id};
   assign elapsed    = req_ff.now_ms - move_start_ff;
   assign e_neg      = elapsed[TIME_W-1];
   assign e_ge       = !e_neg && (elapsed[TIME_W-2:0] >= {15'b0, held_dur_ff});
   assign pose_match = !moving_ff && (held_id_ff == req_id || held_id_ff == NO_ID);
   assign set_apply  = req_ff.op == OP_SET && pose_match &&
                       (held_id_ff != req_id || held_dur_ff != req_ff.duration_ms ||
                        any_diff);
   assign set_start  = req_ff.op == OP_SET && !moving_ff && !pose_match;
   assign set_rebase = req_ff.op == OP_SET && moving_ff && req_id != goal_id_ff;
   assign tick_finish = req_ff.op == OP_TICK && moving_ff && e_ge;
   assign tick_mix    = req_ff.op == OP_TICK && moving_ff && !e_ge;
   assign do_cancel   = req_ff.op == OP_CANCEL && moving_ff;
   assign emit_load   = state_ff == ST_EMIT && (!rsp_valid_ff || rsp_ready);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (set_apply || tick_finish) begin
               state_in = ST_MAP1;
            end else if (set_rebase || tick_mix) begin
               state_in = ST_FRAC;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FRAC:   state_in = (e_neg || e_ge) ? ST_MIX1 : ST_DIVIDE;
         ST_DIVIDE: if (div_done) state_in = ST_MIX1;
         ST_MIX1:   state_in = ST_MIX2;
         ST_MIX2:   state_in = job_rebase_ff ? ST_IDLE : ST_MAP1;
         ST_MAP1:   state_in = ST_MAP2;
         ST_MAP2:   state_in = ST_MAP3;
         ST_MAP3:   state_in = ST_EMIT;
         ST_EMIT:   if (emit_load && !emit_two_ff) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer and pose state updates.
   always_comb begin
      ctrl          = '0;
      req_in        = req_ff;
      held_id_in    = held_id_ff;
      goal_id_in    = goal_id_ff;
      held_dur_in   = held_dur_ff;
      goal_dur_in   = goal_dur_ff;
      move_start_in = move_start_ff;
      moving_in     = moving_ff;
      frac_in       = frac_ff;
      job_rebase_in = job_rebase_ff;
      job_mix_in    = job_mix_ff;
      emit_two_in   = emit_two_ff;
      div_start     = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      ctrl.map_src_mix = job_mix_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) req_in = req_data;
         end
         ST_DECIDE: begin
            job_rebase_in = set_rebase;
            job_mix_in    = tick_mix;
            emit_two_in   = tick_finish;
            if (set_apply) begin
               ctrl.load_held_req = 1'b1;
               held_id_in  = req_id;
               held_dur_in = req_ff.duration_ms;
            end
            if (set_start) begin
               ctrl.load_goal_req = 1'b1;
               goal_id_in    = req_id;
               goal_dur_in   = req_ff.duration_ms;
               move_start_in = req_ff.now_ms;
               moving_in     = 1'b1;
            end
            if (tick_finish) begin
               ctrl.load_held_goal = 1'b1;
               held_id_in  = goal_id_ff;
               held_dur_in = goal_dur_ff;
               goal_id_in  = NO_ID;
               moving_in   = 1'b0;
            end
            if (do_cancel) begin
               held_id_in = NO_ID;
               goal_id_in = NO_ID;
               moving_in  = 1'b0;
            end
         end
         ST_FRAC: begin
            if (e_neg) begin
               frac_in = '0;
            end else if (e_ge) begin
               frac_in = FRAC_ONE;
            end else begin
               div_start = 1'b1;
            end
         end
         ST_DIVIDE: begin
            if (div_done) frac_in = {1'b0, div_quo};
         end
         ST_MIX1: ctrl.mix_mult = 1'b1;
         ST_MIX2: begin
            ctrl.mix_add    = 1'b1;
            ctrl.mix_rebase = job_rebase_ff;
            if (job_rebase_ff) begin
               ctrl.load_goal_req = 1'b1;
               held_id_in    = goal_id_ff;
               goal_id_in    = req_id;
               goal_dur_in   = req_ff.duration_ms;
               move_start_in = req_ff.now_ms;
            end
         end
         ST_MAP1: ctrl.map1 = 1'b1;
         ST_MAP2: ctrl.map2 = 1'b1;
         ST_MAP3: ctrl.map3 = 1'b1;
         ST_EMIT: begin
            if (emit_load) begin
               rsp_valid_in = 1'b1;
               rsp_in       = merged;
               emit_two_in  = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // Configuration registers.
   assign csr_ready = 1'b1;
   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_PULSE_AT_MIN: lo_in = csr_data;
            REG_PULSE_AT_MAX: hi_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         lo_ff         <= PULSE_MIN_RESET;
         hi_ff         <= PULSE_MAX_RESET;
         held_id_ff    <= NO_ID;
         goal_id_ff    <= NO_ID;
         held_dur_ff   <= DUR_RESET;
         goal_dur_ff   <= DUR_RESET;
         move_start_ff <= '0;
         moving_ff     <= 1'b0;
         job_rebase_ff <= 1'b0;
         job_mix_ff    <= 1'b0;
         emit_two_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         lo_ff         <= lo_in;
         hi_ff         <= hi_in;
         held_id_ff    <= held_id_in;
         goal_id_ff    <= goal_id_in;
         held_dur_ff   <= held_dur_in;
         goal_dur_ff   <= goal_dur_in;
         move_start_ff <= move_start_in;
         moving_ff     <= moving_in;
         job_rebase_ff <= job_rebase_in;
         job_mix_ff    <= job_mix_in;
         emit_two_ff   <= emit_two_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      req_ff  <= req_in;
      frac_ff <= frac_in;
      rsp_ff  <= rsp_in;
   end

   // Fraction divider, shared by all channels.
   spose_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (elapsed[DUR_W-1:0]),
      .den   (held_dur_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   // Channel lanes.
   for (genvar g = 0; g < MAX_CH; g++) begin : g_lane
      if (g < CHANNELS) begin : g_on
         spose_lane u_lane (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl),
            .req_angle (req_angles[g]),
            .frac      (frac_ff),
            .pulse_lo  (lo_ff),
            .pulse_hi  (hi_ff),
            .diff      (diffs[g]),
            .pulse     (pulses[g])
         );
      end else begin : g_off
         assign diffs[g]  = 1'b0;
         assign pulses[g] = '0;
      end
   end

   spose_merge #(.CHANNELS(CHANNELS)) u_merge (
      .diffs    (diffs),
      .pulses   (pulses),
      .last     (!emit_two_ff),
      .any_diff (any_diff),
      .rsp      (merged)
   );

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A running move always has a goal pose.
   a_goal_when_moving: assert property (@(posedge clock) disable iff (reset)
      moving_ff |-> goal_id_ff != NO_ID) else $error("moving without goal pose");

   // The divider only runs for a move in progress.
   a_divide_moving: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> moving_ff) else $error("divide while idle");

   // The divider reports only while the sequencer waits for it.
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIVIDE) else $error("stray divider result");

   // A double result comes only from a finished move.
   a_two_after_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && emit_two_ff) |-> !moving_ff)
      else $error("double result while moving");

endmodule
